// ===== design/sawc_pkg.sv =====
// Package for the cache tag store: widths, register indexes and request kinds.
package sawc_pkg;

   localparam int DEF_MAX_SETS  = 256;
   localparam int DEF_MAX_WAYS  = 8;
   localparam int DEF_ADDR_BITS = 32;

   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 4;
   localparam int OFFSET_MAX    = 8;

   typedef enum logic [1:0] {
      KIND_READ  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_INVAL = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      REG_MODE    = 2'd0,
      REG_SETBITS = 2'd1,
      REG_OFFBITS = 2'd2,
      REG_WAYS    = 2'd3
   } reg_idx_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_LOOK,
      ST_DONE
   } state_type;

endpackage

// ===== design/set_assoc_writeback_cache_tags.sv =====
// Top level of the set-associative write-back cache tag store.
//
// Usage: an access (read, write or invalidate) is issued by raising start
// with req_kind and req_address while busy is low. The set is read from the
// memory at the accepting edge, so in the next cycle all ways are compared in
// parallel and the updated tags, dirty bits and age ranks are written back.
// One result is presented on the rsp_ ports for a single cycle with rsp_valid
// high, from the rsp_ registers that capture the compare result. A new access
// can start the cycle the result appears; while a set is being compared, busy
// is high, as the single read-modify-write pass over the set memory is in use.
// The receiver cannot stall the result. The user must write registers through
// the csr_ channel only while the block is idle; the block does not enforce
// this, and csr_ready is always high. After reset the block sweeps the set
// memory, one set per cycle, clearing valid and dirty bits and restoring the
// age order; busy stays high during the sweep. Tags are not cleared.
module set_assoc_writeback_cache_tags #(
   parameter int MAX_SETS  = sawc_pkg::DEF_MAX_SETS,
   parameter int MAX_WAYS  = sawc_pkg::DEF_MAX_WAYS,
   parameter int ADDR_BITS = sawc_pkg::DEF_ADDR_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_kind,
   input  logic [31:0]                        req_address,
   output logic                               rsp_valid,
   output logic                               rsp_hit,
   output logic                               rsp_victim_valid,
   output logic                               rsp_writeback_needed,
   output logic [31:0]                        rsp_victim_address,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [sawc_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [sawc_pkg::CSR_DATA_BITS-1:0] csr_data
);
   import sawc_pkg::*;

   localparam int SIDX = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int WIDX = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int RW   = WIDX;
   localparam int SB_MAX = $clog2(MAX_SETS + 1) - 1;
   localparam int SETS_BITS = SIDX;

   // One memory word holds a whole set.
   typedef struct packed {
      logic [MAX_WAYS-1:0]                valid;
      logic [MAX_WAYS-1:0]                dirty;
      logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tag;
      logic [MAX_WAYS-1:0][RW-1:0]        rank;
   } set_word_type;

   set_word_type mem [MAX_SETS];
   set_word_type rd_data_ff;

   logic        mode_ff;
   logic [3:0]  sbits_ff, obits_ff, ways_ff;
   state_type   state_ff, state_in;
   logic [SETS_BITS:0] clr_ff, clr_in;
   kind_type    kind_ff, kind_in;
   logic [ADDR_BITS-1:0] addr_ff, addr_in;

   logic          wr_en;
   logic [SIDX-1:0] wr_idx, rd_idx;
   set_word_type  wr_word;

   logic [3:0] sb_eff, ob_eff, ways_eff;
   logic [4:0] tag_shift;
   logic [SIDX-1:0] set_idx;
   logic [ADDR_BITS-1:0] tag_val, set_mask;

   logic       res_hit, res_vv, res_wb;
   logic [ADDR_BITS-1:0] res_va;
   logic       rsp_valid_ff, rsp_hit_ff, rsp_vv_ff, rsp_wb_ff;
   logic [31:0] rsp_va_ff;

   assign csr_ready = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         sbits_ff <= 4'd5;
         obits_ff <= 4'd4;
         ways_ff  <= 4'd2;
      end else if (csr_valid && csr_ready) begin
         unique case (reg_idx_type'(csr_index))
            REG_MODE:    mode_ff  <= csr_data[0];
            REG_SETBITS: sbits_ff <= csr_data;
            REG_OFFBITS: obits_ff <= csr_data;
            REG_WAYS:    ways_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      sb_eff = (int'(sbits_ff) > SB_MAX) ? 4'(SB_MAX) : sbits_ff;
      ob_eff = (int'(obits_ff) > OFFSET_MAX) ? 4'(OFFSET_MAX) : obits_ff;
      if (ways_ff == 4'd0) begin
         ways_eff = 4'd1;
      end else if (int'(ways_ff) > MAX_WAYS) begin
         ways_eff = 4'(MAX_WAYS);
      end else begin
         ways_eff = ways_ff;
      end
      // The tag shift can reach 16, so it needs one bit more than the fields.
      tag_shift = 5'(sb_eff) + 5'(ob_eff);
      set_mask = (ADDR_BITS'(1) << sb_eff) - ADDR_BITS'(1);
      set_idx  = SIDX'((addr_ff >> ob_eff) & set_mask);
      tag_val  = addr_ff >> tag_shift;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_ff == (SETS_BITS+1)'(MAX_SETS - 1)) state_in = ST_IDLE;
         ST_IDLE:  if (start) state_in = ST_LOOK;
         ST_LOOK:  state_in = ST_DONE;
         ST_DONE:  state_in = start ? ST_LOOK : ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   assign busy = (state_ff == ST_CLEAR) || (state_ff == ST_LOOK);

   always_comb begin
      clr_in  = (state_ff == ST_CLEAR) ? clr_ff + 1'b1 : clr_ff;
      kind_in = kind_ff;
      addr_in = addr_ff;
      if (start && !busy) begin
         kind_in = kind_type'(req_kind);
         addr_in = ADDR_BITS'(req_address);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      addr_ff <= addr_in;
   end

   // Set index is computed from the incoming address at the read.
   logic [3:0] sb_r, ob_r;
   assign sb_r = sb_eff;
   assign ob_r = ob_eff;
   assign rd_idx = SIDX'((ADDR_BITS'(req_address) >> ob_r) &
                         ((ADDR_BITS'(1) << sb_r) - ADDR_BITS'(1)));

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_idx] <= wr_word;
      rd_data_ff <= mem[rd_idx];
   end

   // Compare, choose victim, build write-back word; during the sweep, build the cleared word.
   always_comb begin
      logic [WIDX-1:0] way, old_way;
      logic            found;
      logic [RW-1:0]   old_rank, best;
      set_word_type    w;
      w        = rd_data_ff;
      found    = 1'b0;
      way      = '0;
      old_way  = '0;
      old_rank = '0;
      best     = rd_data_ff.rank[0];
      res_hit  = 1'b0;
      res_vv   = 1'b0;
      res_wb   = 1'b0;
      res_va   = '0;
      for (int i = 0; i < MAX_WAYS; i++) begin
         if (!found && (i < int'(ways_eff)) && rd_data_ff.valid[i] &&
             rd_data_ff.tag[i] == tag_val) begin
            found = 1'b1;
            way   = WIDX'(i);
         end
      end
      for (int i = 1; i < MAX_WAYS; i++) begin
         if ((i < int'(ways_eff)) && rd_data_ff.rank[i] < best) begin
            best    = rd_data_ff.rank[i];
            old_way = WIDX'(i);
         end
      end
      wr_en  = 1'b0;
      wr_idx = set_idx;
      if (state_ff == ST_CLEAR) begin
         wr_en  = 1'b1;
         wr_idx = clr_ff[SIDX-1:0];
         w.valid = '0;
         w.dirty = '0;
         for (int i = 0; i < MAX_WAYS; i++) w.rank[i] = RW'(i);
      end else if (state_ff == ST_LOOK && kind_ff != KIND_NONE) begin
         res_hit = found;
         if (kind_ff == KIND_INVAL) begin
            if (found) begin
               wr_en        = 1'b1;
               res_wb       = rd_data_ff.dirty[way];
               res_va       = (tag_val << tag_shift) |
                              (ADDR_BITS'(set_idx) << ob_eff);
               w.valid[way] = 1'b0;
               w.dirty[way] = 1'b0;
            end
         end else begin
            wr_en = 1'b1;
            if (!found) begin
               way = old_way;
               if (rd_data_ff.valid[way]) begin
                  res_vv = 1'b1;
                  res_wb = rd_data_ff.dirty[way];
                  res_va = (rd_data_ff.tag[way] << tag_shift) |
                           (ADDR_BITS'(set_idx) << ob_eff);
               end
               w.valid[way] = 1'b1;
               w.tag[way]   = tag_val;
               w.dirty[way] = 1'b0;
            end
            if (kind_ff == KIND_WRITE) w.dirty[way] = 1'b1;
            if (!mode_ff || !found) begin
               old_rank = rd_data_ff.rank[way];
               for (int i = 0; i < MAX_WAYS; i++) begin
                  if (rd_data_ff.rank[i] > old_rank) w.rank[i] = rd_data_ff.rank[i] - 1'b1;
               end
               w.rank[way] = RW'(MAX_WAYS - 1);
            end
         end
      end
      wr_word = w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == ST_LOOK);
      end
      rsp_hit_ff <= res_hit;
      rsp_vv_ff  <= res_vv;
      rsp_wb_ff  <= res_wb;
      rsp_va_ff  <= 32'(res_va);
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_hit              = rsp_hit_ff;
   assign rsp_victim_valid     = rsp_vv_ff;
   assign rsp_writeback_needed = rsp_wb_ff;
   assign rsp_victim_address   = rsp_va_ff;

   a_victim_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_hit && rsp_victim_valid))
      else $error("victim reported on a hit");
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held two cycles");
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOK) |=> rsp_valid)
      else $error("lookup without result");
   a_no_vv_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_victim_valid && !rsp_writeback_needed |->
         rsp_victim_address == 32'd0 || rsp_hit)
      else $error("victim address without victim");

endmodule
